>>> hdl/mmpa_pkg.sv
`default_nettype none
package mmpa_pkg;

  localparam int unsigned MAX_ENTRIES = 64;
  localparam int unsigned PAGE_BYTES  = 4096;

  localparam int unsigned CNT_W   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned IDX_W   = $clog2(MAX_ENTRIES);
  localparam int unsigned ALIGN_W = 33;
  localparam int unsigned IN_W    = 200;
  localparam int unsigned OUT_W   = 208;

  localparam logic [ALIGN_W-1:0] ALIGN_RESET = ALIGN_W'(4096);

  localparam logic [1:0] TYPE_USED = 2'd0;
  localparam logic [1:0] TYPE_FREE = 2'd1;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_ALIGN = 2'd1,
    FUNC_ALLOC = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_AL_RD,
    S_AL_WAIT,
    S_AL_REM1,
    S_AL_REM2,
    S_AC_RD,
    S_AC_CHK,
    S_SH_RD,
    S_SH_WR,
    S_SPLIT_HI,
    S_SPLIT_LO,
    S_ST_RD,
    S_ST_ACC,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  typ;
    logic [63:0] size;
    logic [63:0] base;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic clr;
    logic acc;
  } stats_ctl_t;

endpackage
`default_nettype wire

>>> hdl/mmpa_ram.sv
`default_nettype none
module mmpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> hdl/mmpa_rem.sv
`default_nettype none
module mmpa_rem
  import mmpa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [63:0]        dividend_i,
  input  wire logic [ALIGN_W-1:0] divisor_i,
  output logic                    done_o,
  output logic      [ALIGN_W-1:0] rem_o
);

  logic               busy_q, busy_d, done_q, done_d;
  logic [5:0]         step_q, step_d;
  logic [63:0]        dvd_q, dvd_d;
  logic [ALIGN_W-1:0] dvs_q, dvs_d, r_q, r_d;
  logic [ALIGN_W:0]   trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    r_d    = r_q;
    trial  = {r_q, dvd_q[63]};
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      r_d    = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        r_d = ALIGN_W'(trial - {1'b0, dvs_q});
      end else begin
        r_d = trial[ALIGN_W-1:0];
      end
      dvd_d  = {dvd_q[62:0], 1'b0};
      step_d = step_q + 6'd1;
      if (step_q == 6'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    r_q   <= r_d;
  end

  assign done_o = done_q;
  assign rem_o  = r_q;

endmodule
`default_nettype wire

>>> hdl/mmpa_stats.sv
`default_nettype none
module mmpa_stats
  import mmpa_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire stats_ctl_t  ctl_i,
  input  wire entry_t      entry_i,
  output logic      [63:0] top_o,
  output logic      [63:0] sum_o
);

  logic [63:0] top_q, top_d, sum_q, sum_d, t;
  logic [64:0] t_full, s_full;

  always_comb begin
    top_d  = top_q;
    sum_d  = sum_q;
    t_full = {1'b0, entry_i.base} + {1'b0, entry_i.size};
    s_full = {1'b0, sum_q} + {1'b0, entry_i.size};
    t      = t_full[64] ? '1 : t_full[63:0];
    if (ctl_i.clr) begin
      top_d = '0;
      sum_d = '0;
    end else if (ctl_i.acc && entry_i.typ == TYPE_FREE) begin
      if (t > top_q) begin
        top_d = t;
      end
      sum_d = s_full[64] ? '1 : s_full[63:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
      sum_q <= '0;
    end else begin
      top_q <= top_d;
      sum_q <= sum_d;
    end
  end

  assign top_o = top_q;
  assign sum_o = sum_q;

endmodule
`default_nettype wire

>>> hdl/memory_map_page_allocator_unit.sv
// channel  dir  fields (low bit up)
// s        in   tuser: func[1:0]; tdata: entry_base, entry_size, entry_type, request_bytes
// m        out  tdata: status, alloc_base, region_count, highest_free_top, total_free
// cfg      in   cfg_wdata: align_bytes[32:0]
// one beat at a time; every op ends with a stats walk over all N regions
// load: one table write; allocate: top-down search, shift entries up, split the hit in two
// align: per region, two serial remainder passes, one on the base and one on the size
// table lives in one single-port-write ram of MAX_ENTRIES entries; reset clears only the count
// a finished result waits in the output register; a stalled master holds only the final step
`default_nettype none
module memory_map_page_allocator_unit
  import mmpa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_tvalid_i,
  output logic                    s_tready_o,
  input  wire logic [IN_W-1:0]    s_tdata_i,   // entry_base, entry_size, entry_type, request_bytes
  input  wire logic [1:0]         s_tuser_i,   // func
  output logic                    m_tvalid_o,
  input  wire logic               m_tready_i,
  output logic      [OUT_W-1:0]   m_tdata_o,   // status, alloc_base, region_count, top, free
  input  wire logic               cfg_we_i,
  input  wire logic [ALIGN_W-1:0] cfg_wdata_i
);

  state_e             state_q, state_d;
  status_e            status_q, status_d;
  entry_t             ld_q, ld_d, hit_q, hit_d, rdata, wdata;
  logic [63:0]        req_q, req_d, abase_q, abase_d, wb_q, wb_d, ws_q, ws_d;
  logic [1:0]         wt_q, wt_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d, idx_q, idx_d, j_q, j_d;
  logic [ALIGN_W-1:0] align_q, a_q, a_d;
  logic               mv_q, mv_d;
  logic [OUT_W-1:0]   mdata_q, mdata_d;
  logic               we, re;
  logic [IDX_W-1:0]   waddr, raddr;
  logic               rem_start, rem_done;
  logic [63:0]        rem_dvd, d64, wb_adj, ws_adj;
  logic [ALIGN_W-1:0] rem_val;
  logic [64:0]        rnd;
  logic [63:0]        in_req;
  stats_ctl_t         sctl;
  logic [63:0]        st_top, st_sum;

  mmpa_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  mmpa_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (rem_dvd),
    .divisor_i  (a_q),
    .done_o     (rem_done),
    .rem_o      (rem_val)
  );

  mmpa_stats u_stats (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (sctl),
    .entry_i (rdata),
    .top_o   (st_top),
    .sum_o   (st_sum)
  );

  assign in_req = s_tdata_i[193:130];
  assign rnd    = {1'b0, in_req} + 65'(PAGE_BYTES - 1);
  assign d64    = 64'(a_q - rem_val);
  assign wb_adj = (rem_val != '0) ? wb_q + d64 : wb_q;
  assign ws_adj = (rem_val == '0) ? ws_q : ((ws_q > d64) ? ws_q - d64 : '0);

  always_comb begin
    state_d   = state_q;
    status_d  = status_q;
    ld_d      = ld_q;
    hit_d     = hit_q;
    req_d     = req_q;
    abase_d   = abase_q;
    wb_d      = wb_q;
    ws_d      = ws_q;
    wt_d      = wt_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    j_d       = j_q;
    a_d       = a_q;
    mv_d      = mv_q;
    mdata_d   = mdata_q;
    we        = 1'b0;
    re        = 1'b0;
    waddr     = idx_q[IDX_W-1:0];
    raddr     = idx_q[IDX_W-1:0];
    wdata     = ld_q;
    rem_start = 1'b0;
    rem_dvd   = rdata.base;
    sctl      = '0;
    s_tready_o = (state_q == S_IDLE);

    if (mv_q && m_tready_i) begin
      mv_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_tvalid_i) begin
          ld_d     = '{typ: s_tdata_i[129:128], size: s_tdata_i[127:64],
                       base: s_tdata_i[63:0]};
          req_d    = rnd[63:0] & ~64'(PAGE_BYTES - 1);
          status_d = ST_OK;
          abase_d  = '0;
          a_d      = (align_q == '0) ? ALIGN_W'(1) : align_q;
          sctl.clr = 1'b1;
          idx_d    = '0;
          state_d  = S_ST_RD;
          case (func_e'(s_tuser_i))
            FUNC_LOAD: begin
              if (cnt_q >= CNT_W'(MAX_ENTRIES)) begin
                status_d = ST_FULL;
              end else begin
                state_d = S_LOAD;
              end
            end
            FUNC_ALIGN: begin
              if (cnt_q != '0) begin
                state_d = S_AL_RD;
              end
            end
            FUNC_ALLOC: begin
              if (rnd[64] || cnt_q < CNT_W'(2)) begin
                status_d = ST_NOFIT;
              end else begin
                idx_d   = cnt_q - CNT_W'(1);
                state_d = S_AC_RD;
              end
            end
            default: begin
              state_d = S_ST_RD;
            end
          endcase
        end
      end
      S_LOAD: begin
        we      = 1'b1;
        waddr   = cnt_q[IDX_W-1:0];
        wdata   = ld_q;
        cnt_d   = cnt_q + CNT_W'(1);
        state_d = S_ST_RD;
      end
      S_AL_RD: begin
        re      = 1'b1;
        state_d = S_AL_WAIT;
      end
      S_AL_WAIT: begin
        wb_d      = rdata.base;
        ws_d      = rdata.size;
        wt_d      = rdata.typ;
        rem_dvd   = rdata.base;
        rem_start = 1'b1;
        state_d   = S_AL_REM1;
      end
      S_AL_REM1: begin
        if (rem_done) begin
          wb_d      = wb_adj;
          ws_d      = ws_adj;
          rem_dvd   = ws_adj;
          rem_start = 1'b1;
          state_d   = S_AL_REM2;
        end
      end
      S_AL_REM2: begin
        if (rem_done) begin
          we    = 1'b1;
          wdata = '{typ: wt_q, size: ws_q - 64'(rem_val), base: wb_q};
          idx_d = idx_q + CNT_W'(1);
          if (idx_q + CNT_W'(1) == cnt_q) begin
            idx_d   = '0;
            state_d = S_ST_RD;
          end else begin
            state_d = S_AL_RD;
          end
        end
      end
      S_AC_RD: begin
        re      = 1'b1;
        state_d = S_AC_CHK;
      end
      S_AC_CHK: begin
        if (rdata.typ == TYPE_FREE && rdata.size >= req_q) begin
          if (cnt_q >= CNT_W'(MAX_ENTRIES)) begin
            status_d = ST_FULL;
            idx_d    = '0;
            state_d  = S_ST_RD;
          end else begin
            hit_d   = rdata;
            j_d     = cnt_q;
            state_d = S_SH_RD;
          end
        end else if (idx_q == CNT_W'(1)) begin
          status_d = ST_NOFIT;
          idx_d    = '0;
          state_d  = S_ST_RD;
        end else begin
          idx_d   = idx_q - CNT_W'(1);
          state_d = S_AC_RD;
        end
      end
      S_SH_RD: begin
        if (j_q == idx_q + CNT_W'(1)) begin
          state_d = S_SPLIT_HI;
        end else begin
          re      = 1'b1;
          raddr   = IDX_W'(j_q - CNT_W'(1));
          state_d = S_SH_WR;
        end
      end
      S_SH_WR: begin
        we      = 1'b1;
        waddr   = j_q[IDX_W-1:0];
        wdata   = rdata;
        j_d     = j_q - CNT_W'(1);
        state_d = S_SH_RD;
      end
      S_SPLIT_HI: begin
        we      = 1'b1;
        waddr   = IDX_W'(idx_q + CNT_W'(1));
        wdata   = '{typ: TYPE_FREE, size: hit_q.size - req_q, base: hit_q.base + req_q};
        state_d = S_SPLIT_LO;
      end
      S_SPLIT_LO: begin
        we      = 1'b1;
        wdata   = '{typ: TYPE_USED, size: req_q, base: hit_q.base};
        cnt_d   = cnt_q + CNT_W'(1);
        abase_d = hit_q.base;
        idx_d   = '0;
        state_d = S_ST_RD;
      end
      S_ST_RD: begin
        if (idx_q == cnt_q) begin
          state_d = S_DONE;
        end else begin
          re      = 1'b1;
          state_d = S_ST_ACC;
        end
      end
      S_ST_ACC: begin
        sctl.acc = 1'b1;
        idx_d    = idx_q + CNT_W'(1);
        state_d  = S_ST_RD;
      end
      S_DONE: begin
        if (!mv_q || m_tready_i) begin
          mv_d    = 1'b1;
          mdata_d = OUT_W'({st_sum, st_top, cnt_q, abase_q, status_q});
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      mv_q    <= 1'b0;
      align_q <= ALIGN_RESET;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      mv_q    <= mv_d;
      if (cfg_we_i) begin
        align_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    ld_q     <= ld_d;
    hit_q    <= hit_d;
    req_q    <= req_d;
    abase_q  <= abase_d;
    wb_q     <= wb_d;
    ws_q     <= ws_d;
    wt_q     <= wt_d;
    idx_q    <= idx_d;
    j_q      <= j_d;
    a_q      <= a_d;
    mdata_q  <= mdata_d;
  end

  assign m_tvalid_o = mv_q;
  assign m_tdata_o  = mdata_q;

endmodule
`default_nettype wire

>>> bench/memory_map_page_allocator_unit_check.sv
module memory_map_page_allocator_unit_check
  import mmpa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  input  logic               s_tready_i,
  input  logic [IN_W-1:0]    s_tdata_i,
  input  logic [1:0]         s_tuser_i,
  input  logic               m_tvalid_i,
  input  logic               m_tready_i,
  input  logic [OUT_W-1:0]   m_tdata_i,
  input  logic               cfg_we_i,
  input  logic [ALIGN_W-1:0] cfg_wdata_i,
  output int                 fails_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] ALL_ONES = '1;

  typedef struct packed {
    logic [63:0] free_sum;
    logic [63:0] free_top;
    logic [6:0]  count;
    logic [63:0] grant_base;
    logic [1:0]  status;
  } summary_t;

  logic [63:0]        map_base[MAX_ENTRIES];
  logic [63:0]        map_size[MAX_ENTRIES];
  logic [1:0]         map_kind[MAX_ENTRIES];
  int unsigned        map_count;
  logic [ALIGN_W-1:0] granule;
  summary_t           pending_q[$];
  int                 mismatches;

  function automatic void trim_regions();
    logic [63:0] g;
    logic [63:0] r;
    logic [63:0] d;
    g = (granule == '0) ? 64'd1 : {31'd0, granule};
    for (int i = 0; i < map_count; i++) begin
      r = map_base[i] % g;
      if (r != 0) begin
        d = g - r;
        map_base[i] = map_base[i] + d;
        map_size[i] = (map_size[i] > d) ? map_size[i] - d : 64'd0;
      end
      map_size[i] = map_size[i] - (map_size[i] % g);
    end
  endfunction

  function automatic logic [1:0] carve_pages(logic [63:0] req, output logic [63:0] got);
    logic [64:0] need;
    logic        found;
    got = '0;
    need = {1'b0, req};
    if (req[11:0] != 0) need = {1'b0, req} + 65'(PAGE_BYTES - req[11:0]);
    if (need[64]) return ST_NOFIT;
    if (map_count < 2) return ST_NOFIT;
    found = 1'b0;
    for (int i = map_count - 1; i > 0 && !found; i--) begin
      if (map_kind[i] == TYPE_FREE && map_size[i] >= need[63:0]) begin
        found = 1'b1;
        if (map_count >= MAX_ENTRIES) return ST_FULL;
        for (int j = map_count; j > i; j--) begin
          map_base[j] = map_base[j-1];
          map_size[j] = map_size[j-1];
          map_kind[j] = map_kind[j-1];
        end
        map_count++;
        map_size[i] = need[63:0];
        map_kind[i] = TYPE_USED;
        map_base[i+1] = map_base[i+1] + need[63:0];
        map_size[i+1] = map_size[i+1] - need[63:0];
        got = map_base[i];
      end
    end
    return found ? ST_OK : ST_NOFIT;
  endfunction

  function automatic summary_t predict_beat(func_e f, logic [63:0] b, logic [63:0] s,
                                            logic [1:0] k, logic [63:0] req);
    summary_t    res;
    logic [64:0] t;
    logic [64:0] acc;
    logic [63:0] got;
    res = '0;
    res.status = ST_OK;
    case (f)
      FUNC_LOAD: begin
        if (map_count >= MAX_ENTRIES) begin
          res.status = ST_FULL;
        end else begin
          map_base[map_count] = b;
          map_size[map_count] = s;
          map_kind[map_count] = k;
          map_count++;
        end
      end
      FUNC_ALIGN: trim_regions();
      FUNC_ALLOC: begin
        res.status = carve_pages(req, got);
        res.grant_base = (res.status == ST_OK) ? got : 64'd0;
      end
      default: ;
    endcase
    acc = '0;
    for (int i = 0; i < map_count; i++) begin
      if (map_kind[i] == TYPE_FREE) begin
        t = {1'b0, map_base[i]} + {1'b0, map_size[i]};
        if (t[64]) t = {1'b0, ALL_ONES};
        if (t[63:0] > res.free_top) res.free_top = t[63:0];
        acc = acc + {1'b0, map_size[i]};
        if (acc[64]) acc = {1'b0, ALL_ONES};
      end
    end
    res.free_sum = acc[63:0];
    res.count = 7'(map_count);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    summary_t want;
    summary_t seen;
    if (!rst_ni) begin
      map_count = 0;
      granule = ALIGN_RESET;
      pending_q.delete();
      mismatches = 0;
      fails_o <= 0;
    end else begin
      if (cfg_we_i) granule = cfg_wdata_i;
      if (s_tvalid_i && s_tready_i) begin
        pending_q.push_back(predict_beat(func_e'(s_tuser_i), s_tdata_i[63:0],
                                         s_tdata_i[127:64], s_tdata_i[129:128],
                                         s_tdata_i[193:130]));
      end
      if (m_tvalid_i && m_tready_i) begin
        seen = m_tdata_i[$bits(summary_t)-1:0];
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %h", seen);
        end else begin
          want = pending_q.pop_front();
          if (seen.status !== want.status || seen.grant_base !== want.grant_base ||
              seen.count !== want.count || seen.free_top !== want.free_top ||
              seen.free_sum !== want.free_sum) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch at %0t: status %0d/%0d base %h/%h count %0d/%0d",
                       $realtime, want.status, seen.status, want.grant_base,
                       seen.grant_base, want.count, seen.count);
              $display("  top %h/%h free %h/%h (expected/actual)", want.free_top,
                       seen.free_top, want.free_sum, seen.free_sum);
            end
          end
        end
      end
      fails_o <= mismatches + pending_q.size();
    end
  end

endmodule

>>> bench/memory_map_page_allocator_unit_test.sv
module memory_map_page_allocator_unit_test;
  import mmpa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  REGION_ACPI = 2'd2;
  localparam logic [1:0]  REGION_MMIO = 2'd3;
  localparam logic [63:0] ALL_ONES    = '1;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_tvalid_i = 1'b0;
  logic               s_tready_o;
  logic [IN_W-1:0]    s_tdata_i = '0;
  logic [1:0]         s_tuser_i = FUNC_NOP;
  logic               m_tvalid_o;
  logic               m_tready_i = 1'b0;
  logic [OUT_W-1:0]   m_tdata_o;
  logic               cfg_we_i = 1'b0;
  logic [ALIGN_W-1:0] cfg_wdata_i = '0;

  int  fails;
  int  sent_beats = 0;
  int  got_beats = 0;
  int  granule_writes = 0;
  bit  quiet = 1'b0;

  always #4 clk_i = ~clk_i;

  memory_map_page_allocator_unit u_dut (.*);

  memory_map_page_allocator_unit_check u_check (
    .clk_i, .rst_ni, .s_tvalid_i, .s_tready_i(s_tready_o), .s_tdata_i, .s_tuser_i,
    .m_tvalid_i(m_tvalid_o), .m_tready_i, .m_tdata_i(m_tdata_o), .cfg_we_i, .cfg_wdata_i,
    .fails_o(fails)
  );

  always @(posedge clk_i) begin
    if (s_tvalid_i && s_tready_o) sent_beats <= sent_beats + 1;
    if (m_tvalid_o && m_tready_i) got_beats <= got_beats + 1;
  end

  // result side stalls
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      gap = quiet ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        m_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_tready_i <= 1'b1;
      do @(negedge clk_i); while (!m_tvalid_o);
    end
  end

  task automatic put_beat(func_e f, logic [63:0] b, logic [63:0] s, logic [1:0] k,
                          logic [63:0] req);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i <= f;
    s_tdata_i <= {6'd0, req, k, s, b};
    do @(negedge clk_i); while (!s_tready_o);
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (got_beats != sent_beats) @(posedge clk_i);
  endtask

  task automatic write_granule(logic [ALIGN_W-1:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    granule_writes++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_span();
    case ($urandom_range(0, 9))
      0:       return rand64();
      1:       return 64'd0;
      2:       return ALL_ONES - 64'($urandom_range(0, 8191));
      3:       return 64'($urandom_range(0, 65535));
      default: return 64'($urandom_range(1, 256)) << 12;
    endcase
  endfunction

  task automatic random_beat();
    int          pick;
    logic [1:0]  kind;
    logic [63:0] req;
    pick = $urandom_range(0, 99);
    kind = ($urandom_range(0, 9) < 6) ? TYPE_FREE : 2'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0:       req = rand64();
      1:       req = ALL_ONES;
      2:       req = 64'd0;
      default: req = 64'($urandom_range(0, 300000));
    endcase
    if (pick < 30)      put_beat(FUNC_LOAD, pick_span(), pick_span(), kind, rand64());
    else if (pick < 90) put_beat(FUNC_ALLOC, rand64(), rand64(), 2'($urandom), req);
    else if (pick < 95) put_beat(FUNC_ALIGN, rand64(), rand64(), 2'($urandom), rand64());
    else                put_beat(FUNC_NOP, rand64(), rand64(), 2'($urandom), rand64());
  endtask

  initial begin
    #50ms;
    $display("memory_map_page_allocator_unit_test: errors");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    put_beat(FUNC_ALLOC, 0, 0, TYPE_USED, 64'd4096);
    put_beat(FUNC_ALIGN, 0, 0, TYPE_USED, 0);
    put_beat(FUNC_NOP, ALL_ONES, ALL_ONES, REGION_MMIO, ALL_ONES);
    put_beat(FUNC_LOAD, 0, 0, TYPE_FREE, 0);
    put_beat(FUNC_ALLOC, 0, 0, TYPE_USED, 64'd1);
    put_beat(FUNC_LOAD, 64'h1234, 64'h10_0000, TYPE_FREE, 0);
    put_beat(FUNC_LOAD, ALL_ONES, ALL_ONES, TYPE_FREE, 0);
    put_beat(FUNC_LOAD, 64'h8000_0001, 64'h20_0000, TYPE_USED, 0);
    put_beat(FUNC_LOAD, 64'h9000_0000, 64'h1000, REGION_ACPI, 0);
    put_beat(FUNC_LOAD, 64'hFEC0_0000, 64'h1000, REGION_MMIO, 0);
    put_beat(FUNC_LOAD, 64'h10_0FFF, 64'h800, TYPE_FREE, 0);
    put_beat(FUNC_ALLOC, 0, 0, TYPE_USED, 64'd0);
    put_beat(FUNC_ALLOC, 0, 0, TYPE_USED, 64'd1);
    put_beat(FUNC_ALLOC, 0, 0, TYPE_USED, ALL_ONES);
    put_beat(FUNC_ALLOC, 0, 0, TYPE_USED, ALL_ONES - 64'd4095);
    put_beat(FUNC_ALLOC, 0, 0, TYPE_USED, 64'h4_0000);
    put_beat(FUNC_ALIGN, 0, 0, TYPE_USED, 0);
    write_granule('0);
    put_beat(FUNC_ALIGN, 0, 0, TYPE_USED, 0);
    put_beat(FUNC_LOAD, 64'h3_0003, 64'h5_0005, TYPE_FREE, 0);
    write_granule(33'h1_0000_0000);
    put_beat(FUNC_ALIGN, 0, 0, TYPE_USED, 0);
    write_granule(33'd1);
    put_beat(FUNC_ALIGN, 0, 0, TYPE_USED, 0);
    write_granule(ALIGN_RESET);

    // random
    for (int i = 0; i < 680; i++) begin
      if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (i % 170 == 169) write_granule(33'($urandom_range(1, 65536)));
      if (i == 340) write_granule({1'b0, $urandom} | 33'd1);
      if (i == 510) write_granule(33'h1_0000_0000);
      random_beat();
    end

    drain();
    repeat (40) @(posedge clk_i);
    $display("%0d operation beats and %0d granule writes, table driven from empty to full",
             sent_beats, granule_writes);
    if (fails == 0) begin
      $display("memory_map_page_allocator_unit_test: clean");
    end else begin
      $display("memory_map_page_allocator_unit_test: errors");
    end
    $finish;
  end

endmodule
